// ===== rtl/core/hpid_pkg.sv =====
package hpid_pkg;

	// APB address width: eight 32-bit registers at byte addresses 4*i.
	localparam int ADDR_W = 5;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_GAIN_P        = 3'd0,
		REG_GAIN_I        = 3'd1,
		REG_GAIN_D        = 3'd2,
		REG_TARGET_TEMP   = 3'd3,
		REG_RAMP_STEP     = 3'd4,
		REG_OVERTEMP      = 3'd5,
		REG_BOOST_ENTER   = 3'd6,
		REG_BOOST_LEAVE   = 3'd7
	} reg_idx_t;

	// Input opcodes.
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// How the drive of a result is formed.
	typedef enum logic [1:0] {
		DRV_ZERO = 2'd0,
		DRV_FULL = 2'd1,
		DRV_PID  = 2'd2
	} drive_sel_t;

	// One input transaction.
	typedef struct packed {
		logic               opcode;
		logic signed [15:0] temperature;
		logic [39:0]        time_ms;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic [14:0]        drive;
		logic signed [15:0] ramped_target;
		logic               boosting;
		logic               locked_out;
	} out_item_t;

	// Configuration register contents.
	typedef struct packed {
		logic [15:0]        gain_p;
		logic [15:0]        gain_i_per_tick;
		logic [15:0]        gain_d_per_tick;
		logic signed [15:0] target_temp;
		logic [11:0]        ramp_step;
		logic [14:0]        overtemp_margin;
		logic [14:0]        boost_enter_margin;
		logic [14:0]        boost_leave_rise;
	} cfg_t;

	// Setpoint load request raised by a configuration write.
	typedef struct packed {
		logic               load;
		logic signed [15:0] value;
	} sp_load_t;

endpackage

// ===== rtl/core/heater_pid_with_ramp_boost_lockout.sv =====
// Heater PID controller with setpoint ramp, full-power boost and overtemp lockout.
// Input channel (in_valid/in_ready/in_data): one transaction per control tick or
// clear command, carrying opcode, temperature (1/16 degree) and time_ms.
// Output channel (out_valid/out_ready/out_data): exactly one result transaction per
// input, in order, carrying drive, ramped_target, boosting and locked_out.
// Configuration goes through the APB port; write it only while the block is idle.
// An item passes through the input register (stage one), stage two, stage three and the
// output register (stage four). Throughput is one item per cycle while out_ready stays high:
// the controller state is updated as an item leaves stage one, and the three gain products
// and the final sum and clamp follow in two more stages before the output register.
// When the receiver stalls, the pipeline holds and in_ready falls once all four
// stages are full; no transaction is lost or repeated.
// Reset clears the pipeline, the controller state and restores the register
// defaults; no clearing pass is needed.
module heater_pid_with_ramp_boost_lockout
	import hpid_pkg::*;
#(
	parameter int unsigned LOCK_MS    = 5000,
	parameter int          SUM_LIMIT  = 65535,
	parameter int          DIFF_LIMIT = 4096,
	parameter int          OUT_MAX    = 25600
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic [40:0]        LOCK_W    = 41'(LOCK_MS);
	localparam logic signed [18:0] SUM_HI    = 19'(SUM_LIMIT);
	localparam logic signed [18:0] SUM_LO    = -SUM_HI;
	localparam logic signed [17:0] DIFF_HI   = 18'(DIFF_LIMIT);
	localparam logic signed [17:0] DIFF_LO   = -DIFF_HI;
	localparam logic [15:0]        OUT_MAX_W = 16'(OUT_MAX);

	cfg_t     cfg;
	sp_load_t sp_load;

	hpid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.sp_load (sp_load)
	);

	// Pipeline handshake: each stage moves when the next one has room.
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv2, adv3, adv4, step_fire;

	assign adv4      = !v_s4 || out_ready;
	assign adv3      = !v_s3 || adv4;
	assign adv2      = !v_s2 || adv3;
	assign in_ready  = !v_s1 || adv2;
	assign step_fire = v_s1 && adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv2)     v_s2 <= v_s1;
			if (adv3)     v_s3 <= v_s2;
			if (adv4)     v_s4 <= v_s3;
		end
	end

	// Stage one: input register.
	in_item_t in_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) in_s1 <= in_data;
	end

	// Controller state.
	logic signed [15:0] rs_q;
	logic signed [17:0] es_q;
	logic signed [16:0] le_q;
	logic               boost_q;
	logic signed [15:0] origin_q;
	logic [40:0]        lock_end_q;

	logic signed [15:0] rs_nx;
	logic signed [17:0] es_nx;
	logic signed [16:0] le_nx;
	logic               boost_nx;
	logic signed [15:0] origin_nx;
	logic [40:0]        lock_end_nx;

	// Step logic intermediates.
	logic signed [15:0] temp, tgt, r_max, rs_ramp, origin_now;
	logic signed [17:0] r_add, diff_raw;
	logic [40:0]        now;
	logic               overtemp, locked, enter, boost_now, hold;
	logic signed [16:0] err, le_base, diff_c;
	logic signed [17:0] es_base, es_c;
	logic signed [18:0] es_sum;

	// Outgoing stage-two values.
	drive_sel_t         sel_nx;
	logic               boosting_nx, locked_out_nx;

	assign temp = in_s1.temperature;
	assign tgt  = cfg.target_temp;
	assign now  = {1'b0, in_s1.time_ms};

	// Threshold tests, ramp and PID error terms for the item in stage one.
	always_comb begin
		overtemp = 18'(temp) >= 18'(tgt) + $signed({3'b0, cfg.overtemp_margin});
		locked   = now < lock_end_q;

		r_max = (rs_q < temp) ? temp : rs_q;
		r_add = 18'(r_max) + $signed({6'b0, cfg.ramp_step});
		if (cfg.ramp_step == 12'd0) begin
			rs_ramp = tgt;
		end else if (r_max < tgt) begin
			rs_ramp = (r_add > 18'(tgt)) ? tgt : r_add[15:0];
		end else begin
			rs_ramp = tgt;
		end

		enter      = !boost_q &&
			((18'(tgt) - 18'(temp)) > $signed({3'b0, cfg.boost_enter_margin}));
		boost_now  = boost_q || enter;
		origin_now = enter ? temp : origin_q;
		hold       = boost_now &&
			(18'(temp) < 18'(origin_now) + $signed({3'b0, cfg.boost_leave_rise}));

		err     = 17'(rs_ramp) - 17'(temp);
		es_base = boost_now ? 18'sd0 : es_q;
		le_base = boost_now ? err : le_q;

		es_sum = 19'(es_base) + 19'(err);
		if (es_sum > SUM_HI) begin
			es_c = SUM_HI[17:0];
		end else if (es_sum < SUM_LO) begin
			es_c = SUM_LO[17:0];
		end else begin
			es_c = es_sum[17:0];
		end

		diff_raw = 18'(err) - 18'(le_base);
		if (diff_raw > DIFF_HI) begin
			diff_c = DIFF_HI[16:0];
		end else if (diff_raw < DIFF_LO) begin
			diff_c = DIFF_LO[16:0];
		end else begin
			diff_c = diff_raw[16:0];
		end
	end

	// Next controller state and result flags.
	always_comb begin
		rs_nx         = rs_q;
		es_nx         = es_q;
		le_nx         = le_q;
		boost_nx      = boost_q;
		origin_nx     = origin_q;
		lock_end_nx   = lock_end_q;
		sel_nx        = DRV_ZERO;
		boosting_nx   = boost_q;
		locked_out_nx = 1'b0;
		if (in_s1.opcode == OP_CLEAR) begin
			es_nx       = '0;
			le_nx       = '0;
			boost_nx    = 1'b0;
			origin_nx   = '0;
			lock_end_nx = '0;
			if (cfg.ramp_step == 12'd0) rs_nx = tgt;
			boosting_nx = 1'b0;
		end else if (overtemp) begin
			lock_end_nx   = now + LOCK_W;
			es_nx         = '0;
			le_nx         = '0;
			boost_nx      = 1'b0;
			boosting_nx   = 1'b0;
			locked_out_nx = (LOCK_W != 41'd0);
		end else if (locked) begin
			es_nx         = '0;
			locked_out_nx = 1'b1;
		end else begin
			rs_nx     = rs_ramp;
			origin_nx = origin_now;
			if (hold) begin
				boost_nx    = 1'b1;
				es_nx       = enter ? 18'sd0 : es_q;
				le_nx       = enter ? 17'sd0 : le_q;
				sel_nx      = DRV_FULL;
				boosting_nx = 1'b1;
			end else begin
				boost_nx    = 1'b0;
				es_nx       = es_c;
				le_nx       = err;
				sel_nx      = DRV_PID;
				boosting_nx = 1'b0;
			end
		end
	end

	// State registers; a setpoint load from a configuration write takes priority.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q       <= '0;
			es_q       <= '0;
			le_q       <= '0;
			boost_q    <= 1'b0;
			origin_q   <= '0;
			lock_end_q <= '0;
		end else begin
			if (sp_load.load) begin
				rs_q <= sp_load.value;
			end else if (step_fire) begin
				rs_q <= rs_nx;
			end
			if (step_fire) begin
				es_q       <= es_nx;
				le_q       <= le_nx;
				boost_q    <= boost_nx;
				origin_q   <= origin_nx;
				lock_end_q <= lock_end_nx;
			end
		end
	end

	// Stage two: PID operands and result flags.
	drive_sel_t         sel_s2;
	logic signed [15:0] rs_s2;
	logic               boosting_s2, locked_out_s2;
	logic signed [16:0] err_s2, diff_s2;
	logic signed [17:0] es_s2;

	always_ff @(posedge clk) begin
		if (step_fire) begin
			sel_s2        <= sel_nx;
			rs_s2         <= rs_nx;
			boosting_s2   <= boosting_nx;
			locked_out_s2 <= locked_out_nx;
			err_s2        <= err;
			es_s2         <= es_c;
			diff_s2       <= diff_c;
		end
	end

	// Stage three: the three gain products.
	drive_sel_t         sel_s3;
	logic signed [15:0] rs_s3;
	logic               boosting_s3, locked_out_s3;
	logic signed [33:0] prod_p_s3, prod_d_s3;
	logic signed [34:0] prod_i_s3;

	always_ff @(posedge clk) begin
		if (v_s2 && adv3) begin
			sel_s3        <= sel_s2;
			rs_s3         <= rs_s2;
			boosting_s3   <= boosting_s2;
			locked_out_s3 <= locked_out_s2;
			prod_p_s3     <= $signed({1'b0, cfg.gain_p}) * err_s2;
			prod_i_s3     <= $signed({1'b0, cfg.gain_i_per_tick}) * es_s2;
			prod_d_s3     <= $signed({1'b0, cfg.gain_d_per_tick}) * diff_s2;
		end
	end

	// Sum of products, scaled down by 16 and clamped to the drive range.
	logic signed [35:0] acc, acc_sh;
	logic [15:0]        pid_drive;
	logic [14:0]        drive_nx;

	always_comb begin
		acc    = 36'(prod_p_s3) + 36'(prod_i_s3) + 36'(prod_d_s3);
		acc_sh = acc >>> 4;
		if (acc < 36'sd0) begin
			pid_drive = 16'd0;
		end else if (acc_sh > $signed({20'd0, OUT_MAX_W})) begin
			pid_drive = OUT_MAX_W;
		end else begin
			pid_drive = acc_sh[15:0];
		end
		case (sel_s3)
			DRV_ZERO: drive_nx = 15'd0;
			DRV_FULL: drive_nx = OUT_MAX_W[14:0];
			DRV_PID:  drive_nx = pid_drive[14:0];
			default:  drive_nx = 15'd0;
		endcase
	end

	// Stage four: output register.
	out_item_t out_s4;

	always_ff @(posedge clk) begin
		if (v_s3 && adv4) begin
			out_s4.drive         <= drive_nx;
			out_s4.ramped_target <= rs_s3;
			out_s4.boosting      <= boosting_s3;
			out_s4.locked_out    <= locked_out_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = out_s4;

`ifndef SYNTHESIS
	// A boosting result outside lockout always carries full drive.
	a_boost_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.boosting && !out_data.locked_out
		|-> out_data.drive == OUT_MAX_W[14:0])
		else $error("boosting result without full drive");

	// A locked-out result never drives the heater.
	a_lock_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.locked_out |-> out_data.drive == 15'd0)
		else $error("drive during lockout");

	// Controller state other than the setpoint only changes when an item leaves stage one.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_fire |=> $stable(es_q) && $stable(le_q) && $stable(boost_q)
			&& $stable(lock_end_q))
		else $error("controller state changed without a step");

	// The error sum stays within its limits.
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire |=> (19'(es_q) <= SUM_HI) && (19'(es_q) >= SUM_LO))
		else $error("error sum out of range");
`endif

endmodule

// ===== rtl/core/hpid_regs.sv =====
module hpid_regs
	import hpid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg,
	output sp_load_t          sp_load
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg    = cfg_q;

	// Register file, written in the access phase of a write transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p             <= 16'd256;
			cfg_q.gain_i_per_tick    <= 16'd0;
			cfg_q.gain_d_per_tick    <= 16'd0;
			cfg_q.target_temp        <= 16'sd0;
			cfg_q.ramp_step          <= 12'd0;
			cfg_q.overtemp_margin    <= 15'd160;
			cfg_q.boost_enter_margin <= 15'd320;
			cfg_q.boost_leave_rise   <= 15'd160;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_P:      cfg_q.gain_p             <= pwdata[15:0];
				REG_GAIN_I:      cfg_q.gain_i_per_tick    <= pwdata[15:0];
				REG_GAIN_D:      cfg_q.gain_d_per_tick    <= pwdata[15:0];
				REG_TARGET_TEMP: cfg_q.target_temp        <= $signed(pwdata[15:0]);
				REG_RAMP_STEP:   cfg_q.ramp_step          <= pwdata[11:0];
				REG_OVERTEMP:    cfg_q.overtemp_margin    <= pwdata[14:0];
				REG_BOOST_ENTER: cfg_q.boost_enter_margin <= pwdata[14:0];
				REG_BOOST_LEAVE: cfg_q.boost_leave_rise   <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// A new target while the ramp is off, or turning the ramp off, snaps the controlled setpoint.
	always_comb begin
		sp_load.load  = 1'b0;
		sp_load.value = cfg_q.target_temp;
		if (wr_en) begin
			case (idx)
				REG_TARGET_TEMP: begin
					sp_load.load  = (cfg_q.ramp_step == 12'd0);
					sp_load.value = $signed(pwdata[15:0]);
				end
				REG_RAMP_STEP: begin
					sp_load.load = (pwdata[11:0] == 12'd0);
				end
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (idx)
			REG_GAIN_P:      prdata = {16'd0, cfg_q.gain_p};
			REG_GAIN_I:      prdata = {16'd0, cfg_q.gain_i_per_tick};
			REG_GAIN_D:      prdata = {16'd0, cfg_q.gain_d_per_tick};
			REG_TARGET_TEMP: prdata = {{16{cfg_q.target_temp[15]}}, cfg_q.target_temp};
			REG_RAMP_STEP:   prdata = {20'd0, cfg_q.ramp_step};
			REG_OVERTEMP:    prdata = {17'd0, cfg_q.overtemp_margin};
			REG_BOOST_ENTER: prdata = {17'd0, cfg_q.boost_enter_margin};
			REG_BOOST_LEAVE: prdata = {17'd0, cfg_q.boost_leave_rise};
			default:         prdata = 32'd0;
		endcase
	end

endmodule
